### rtl/ptmlw_pkg.sv
// ----------------------------------------------------------------------------
// ptmlw_pkg
// Shared types and constants for the peak-triggered mirror LED wipe.
// ----------------------------------------------------------------------------
package ptmlw_pkg;

  localparam int MAX_LEDS_DEF = 255;
  localparam int SLOTS        = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int PEAK_W       = 20;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECREMENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN_Q8   = 3'd4;

  // reset values
  localparam logic [7:0]  LED_COUNT_RST  = 8'd60;
  localparam logic [15:0] STEP_DELAY_RST = 16'd10;

  // slots one and two of a step always carry the lit pixels
  localparam logic [SLOTS-1:0] LIT_SLOTS = 4'b0110;

  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  typedef struct packed {
    logic [7:0]  led_count;
    logic [15:0] step_delay_ms;
    logic [15:0] min_peak;
    logic [15:0] peak_decrement;
    logic [9:0]  peak_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic [8:0]        position;
    logic              returning;
    logic              active;
    logic [PEAK_W-1:0] held_peak;
    logic [31:0]       last_step_ms;
    logic [23:0]       color;
  } sweep_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] peak_sample;
    logic [23:0] new_color;
  } item_t;

  typedef struct packed {
    logic [SLOTS-1:0]      mask;
    logic [SLOTS-1:0][7:0] index;
    logic [23:0]           color;
  } batch_t;

endpackage

### rtl/ptmlw_step.sv
// ----------------------------------------------------------------------------
// ptmlw_step
// One animation step plus the peak-hold update for a registered item.
// ----------------------------------------------------------------------------
module ptmlw_step #(
  parameter int MAX_LEDS = ptmlw_pkg::MAX_LEDS_DEF
) (
  input  ptmlw_pkg::cfg_t   cfg,
  input  ptmlw_pkg::sweep_t cur,
  input  ptmlw_pkg::item_t  item,
  output ptmlw_pkg::sweep_t nxt,
  output ptmlw_pkg::batch_t batch
);

  localparam logic [7:0] MaxN = 8'(MAX_LEDS);

  logic [7:0]         n;
  logic signed [10:0] pi;
  logic signed [10:0] nn;
  logic signed [10:0] hh;
  logic signed [10:0] cand [ptmlw_pkg::SLOTS];
  logic [ptmlw_pkg::SLOTS-1:0] en;
  logic               step;
  logic               active_mid;
  logic [25:0]        prod;
  logic [20:0]        boosted;

  assign n    = (cfg.led_count > MaxN) ? MaxN : cfg.led_count;
  assign pi   = 11'(signed'(cur.position));
  assign nn   = signed'({3'b000, n});
  assign hh   = signed'({4'b0000, n[7:1]});
  assign step = cur.active && ((item.now_ms - cur.last_step_ms) >= {16'd0, cfg.step_delay_ms});

  assign prod    = item.peak_sample * cfg.peak_gain_q8;
  assign boosted = {5'd0, item.peak_sample} + {3'd0, prod[25:8]};

  always_comb begin
    if (!cur.returning) begin
      cand[0] = pi + 11'sd1;      en[0] = pi < hh;
      cand[1] = pi;               en[1] = 1'b1;
      cand[2] = nn - 11'sd1 - pi; en[2] = 1'b1;
      cand[3] = nn - 11'sd2 - pi; en[3] = pi < (hh - 11'sd1);
    end else begin
      cand[0] = pi - 11'sd1;      en[0] = pi > 11'sd0;
      cand[1] = pi;               en[1] = pi < hh;
      cand[2] = nn - 11'sd1 - pi; en[2] = pi < hh;
      cand[3] = nn - pi;          en[3] = pi > 11'sd0;
    end
  end

  // drop writes that fall off the strip
  always_comb begin
    batch.color = cur.color;
    for (int k = 0; k < ptmlw_pkg::SLOTS; k++) begin
      batch.index[k] = cand[k][7:0];
      batch.mask[k]  = step && en[k] && (cand[k] >= 11'sd0) && (cand[k] < nn);
    end
  end

  always_comb begin
    nxt        = cur;
    active_mid = cur.active;
    if (step) begin
      nxt.last_step_ms = item.now_ms;
      if (!cur.returning) begin
        nxt.position = cur.position + 9'd1;
        if (pi == hh) begin
          nxt.returning = 1'b1;
          active_mid    = 1'b0;
        end
      end else begin
        nxt.position = cur.position - 9'd1;
        if (pi == 11'sd0) begin
          nxt.returning = 1'b0;
          active_mid    = 1'b0;
        end
      end
    end
    nxt.active = active_mid;
    if (item.peak_sample >= cfg.min_peak) begin
      if (({4'd0, item.peak_sample} > cur.held_peak) && !active_mid) begin
        nxt.held_peak = (boosted > {1'b0, ptmlw_pkg::PEAK_MAX}) ? ptmlw_pkg::PEAK_MAX
                                                               : boosted[19:0];
        nxt.active    = 1'b1;
        nxt.color     = item.new_color;
      end else if (cur.held_peak > {4'd0, cfg.min_peak}) begin
        nxt.held_peak = (cur.held_peak > {4'd0, cfg.peak_decrement})
                        ? cur.held_peak - {4'd0, cfg.peak_decrement} : '0;
      end
    end
  end

endmodule

### rtl/ptmlw_wbuf.sv
// ----------------------------------------------------------------------------
// ptmlw_wbuf
// Holds a step's pixel writes and hands out one beat a cycle under out_ready.
// ----------------------------------------------------------------------------
module ptmlw_wbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ptmlw_pkg::batch_t batch,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        led_index,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              refresh
);

  logic [ptmlw_pkg::SLOTS-1:0]      mask;
  logic [ptmlw_pkg::SLOTS-1:0][7:0] index;
  logic [23:0]                      color;
  logic [ptmlw_pkg::SLOTS-1:0]      low;
  logic [ptmlw_pkg::SLOTS-1:0]      rest;
  logic                             pop;
  logic                             lit;

  assign low       = mask & (~mask + 1'b1);
  assign rest      = mask & ~low;
  assign out_valid = |mask;
  assign pop       = out_valid && out_ready;
  assign refresh   = (rest == '0);
  assign free      = !out_valid || (pop && refresh);
  assign lit       = |(low & ptmlw_pkg::LIT_SLOTS);

  always_comb begin
    led_index = '0;
    for (int k = 0; k < ptmlw_pkg::SLOTS; k++) begin
      led_index = led_index | (index[k] & {8{low[k]}});
    end
  end

  assign red   = lit ? color[23:16] : 8'd0;
  assign green = lit ? color[15:8]  : 8'd0;
  assign blue  = lit ? color[7:0]   : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load && free) begin
      mask <= batch.mask;
    end else if (pop) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      index <= batch.index;
      color <= batch.color;
    end
  end

endmodule

### rtl/peak_triggered_mirror_led_wipe.sv
// ----------------------------------------------------------------------------
// peak_triggered_mirror_led_wipe
// Audio-peak triggered mirror wipe: emits pixel writes for a two-ended sweep.
// ----------------------------------------------------------------------------
// Each input beat is one call (timestamp, peak sample, candidate color). It is
// held in an input register; once the write buffer is free the step and
// peak-hold logic works it out in one pass, commits the sweep state and drops
// zero to four pixel writes into the write buffer, which drives one output
// beat a cycle while out_ready is high. The last write of a step carries
// refresh. An item waits in the step stage until the write buffer has drained
// the previous step; it can load as that step's last beat leaves. A call that
// produces no writes still updates state. Configuration writes are registered
// and must only be issued while idle.
module peak_triggered_mirror_led_wipe #(
  parameter int MAX_LEDS = ptmlw_pkg::MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic [15:0] peak_sample,
  input  logic [7:0]  new_red,
  input  logic [7:0]  new_green,
  input  logic [7:0]  new_blue,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  led_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        refresh
);

  ptmlw_pkg::cfg_t   cfg;
  ptmlw_pkg::sweep_t state;
  ptmlw_pkg::sweep_t state_next;
  ptmlw_pkg::item_t  item;
  ptmlw_pkg::batch_t batch;
  logic              item_valid;
  logic              buf_free;
  logic              advance;

  // Configuration registers: write through, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count      <= ptmlw_pkg::LED_COUNT_RST;
      cfg.step_delay_ms  <= ptmlw_pkg::STEP_DELAY_RST;
      cfg.min_peak       <= '0;
      cfg.peak_decrement <= '0;
      cfg.peak_gain_q8   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ptmlw_pkg::REG_LED_COUNT:      cfg.led_count      <= cfg_data[7:0];
        ptmlw_pkg::REG_STEP_DELAY_MS:  cfg.step_delay_ms  <= cfg_data;
        ptmlw_pkg::REG_MIN_PEAK:       cfg.min_peak       <= cfg_data;
        ptmlw_pkg::REG_PEAK_DECREMENT: cfg.peak_decrement <= cfg_data;
        ptmlw_pkg::REG_PEAK_GAIN_Q8:   cfg.peak_gain_q8   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // The step stage advances once the write buffer can take its whole batch;
  // the sweep state commits in the same cycle so the next item sees it.
  assign advance  = item_valid && buf_free;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Hold the payload while the stage is stalled.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.now_ms      <= now_ms;
      item.peak_sample <= peak_sample;
      item.new_color   <= {new_red, new_green, new_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  ptmlw_step #(
    .MAX_LEDS(MAX_LEDS)
  ) u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .batch(batch)
  );

  ptmlw_wbuf u_wbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .batch    (batch),
    .free     (buf_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_index(led_index),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .refresh  (refresh)
  );

  // A step that produced writes shows them on the next cycle.
  a_batch_shown: assert property (@(posedge clk) disable iff (rst)
    advance && (batch.mask != '0) |=> out_valid)
    else $error("step writes not presented");

  // After the refresh beat leaves with nothing new loaded, the output goes idle.
  a_refresh_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && refresh && !advance |=> !out_valid)
    else $error("beat after refresh");

  // A stalled step stage keeps its item and the sweep state.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item) && $stable(state))
    else $error("step stage lost its item");

endmodule
